// ----- hw/rtl/leb128_varint_decoder_macros.svh -----
// ---------------------------------------------------------------------------
// LEB128 varint decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef LEB128_VARINT_DECODER_MACROS_SVH
`define LEB128_VARINT_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define LEB_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("leb128 assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define LEB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("leb128 assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/leb_pkg.sv -----
// ---------------------------------------------------------------------------
// LEB128 decoder package
// Field widths, status codes and the result tag carried through the queue.
// ---------------------------------------------------------------------------
package leb_pkg;

	localparam int BYTE_W     = 8;
	localparam int GROUP_BITS = 7;
	localparam int MORE_IDX   = 7;
	localparam int COUNT_W    = 4;
	localparam int STATUS_W   = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERLONG  = 2'd1,
		ST_TRUNCATED = 2'd2
	} leb_status_t;

	typedef struct packed {
		leb_status_t          status;
		logic [COUNT_W-1:0]   byte_count;
		logic                 zigzag;
	} leb_tag_t;

	localparam int TAG_W = $bits(leb_tag_t);

endpackage

// ----- hw/rtl/leb128_varint_decoder.sv -----
// ---------------------------------------------------------------------------
// LEB128 varint decoder
// Decodes unsigned LEB128 numbers, one byte per transaction, with optional
// zig-zag decoding and overlong / truncated error reporting.
//
//   channel   dir  contents
//   s_axis    in   tdata[7:0] byte_in, tlast end_of_data, tuser zigzag_mode
//   m_axis    out  tdata[63:0] value, tdata[67:64] byte_count, tuser status
//
// Takes one byte every cycle unless the queue is full; the front end's
// accumulate step is a single shift and OR; no byte waits on the one before.
// A result reaches m_axis through the queue entry, written at the edge that
// accepts its last byte, and then the output register, which loads from the
// queue whenever the register is free or m_axis_tready is high.
// The result queue holds QUEUE_DEPTH numbers; s_axis_tready drops only
// while it is full because m_axis is stalled.
// Reset clears the partial number, empties the queue and clears the output valid flag.
// ---------------------------------------------------------------------------
`include "leb128_varint_decoder_macros.svh"

module leb128_varint_decoder
	import leb_pkg::*;
#(
	parameter int VALUE_BITS  = 64,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,   // [0] zigzag_mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [63:0] value, [67:64] byte_count, [71:68] zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
	localparam int ENTRY_W    = VALUE_BITS + TAG_W;

	logic                  push;
	logic [VALUE_BITS-1:0] push_value;
	leb_tag_t              push_tag;
	logic                  q_full;
	logic                  q_valid;
	logic                  q_pop;
	logic [ENTRY_W-1:0]    q_data;
	logic [63:0]           out_value;
	leb_status_t           out_status;
	logic [COUNT_W-1:0]    out_count;

	leb_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.in_zigzag  (s_axis_tuser),
		.queue_full (q_full),
		.push       (push),
		.push_value (push_value),
		.push_tag   (push_tag)
	);

	leb_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_tag, push_value}),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	leb_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_value    (q_data[VALUE_BITS-1:0]),
		.q_tag      (leb_tag_t'(q_data[ENTRY_W-1:VALUE_BITS])),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (out_value),
		.out_status (out_status),
		.out_count  (out_count)
	);

	assign m_axis_tdata = {4'b0000, out_count, out_value};
	assign m_axis_tuser = out_status;

	`LEB_ASSERT_IMPLIES(a_no_push_when_full, clk, arst_n, push, !q_full)
	`LEB_ASSERT_IMPLIES(a_no_pop_when_empty, clk, arst_n, q_pop, q_valid)
	`LEB_ASSERT_IMPLIES(a_error_value_zero, clk, arst_n, m_axis_tvalid && (out_status != ST_OK), out_value == '0)
	`LEB_ASSERT_IMPLIES(a_overlong_count, clk, arst_n, m_axis_tvalid && (out_status == ST_OVERLONG), out_count == COUNT_W'(MAX_GROUPS))
	`LEB_ASSERT_NEXT(a_pop_loads_output, clk, arst_n, q_pop, m_axis_tvalid)

endmodule

// ----- hw/rtl/leb_fifo.sv -----
// ---------------------------------------------------------------------------
// LEB128 result queue
// Small register FIFO between the byte front end and the output stage.
// ---------------------------------------------------------------------------
module leb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/leb_front.sv -----
// ---------------------------------------------------------------------------
// LEB128 byte front end
// Accumulates 7-bit groups and classifies each byte as continue, done,
// overlong or truncated; finished numbers go to the result queue.
// ---------------------------------------------------------------------------
module leb_front
	import leb_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     in_byte,
	input  logic                  in_last,
	input  logic                  in_zigzag,
	input  logic                  queue_full,
	output logic                  push,
	output logic [VALUE_BITS-1:0] push_value,
	output leb_tag_t              push_tag
);

	localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
	localparam int SHIFT_W    = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] accum_q;
	logic [COUNT_W-1:0]    group_q;

	logic                  accept;
	logic                  more;
	logic [SHIFT_W-1:0]    shift;
	logic [COUNT_W-1:0]    cnt;
	logic [VALUE_BITS-1:0] acc_next;
	logic                  done;
	logic                  overlong;
	logic                  trunc;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign more     = in_byte[MORE_IDX];
	assign shift    = SHIFT_W'(group_q * GROUP_BITS);
	assign cnt      = group_q + COUNT_W'(1);

	// bits shifted past the top of the accumulator are dropped
	assign acc_next = accum_q | (VALUE_BITS'(in_byte[GROUP_BITS-1:0]) << shift);

	assign done     = !more;
	assign overlong = more && (cnt >= COUNT_W'(MAX_GROUPS));
	assign trunc    = more && !overlong && in_last;

	assign push       = accept && (done || overlong || trunc);
	assign push_value = done ? acc_next : '0;

	always_comb begin
		push_tag.byte_count = cnt;
		push_tag.zigzag     = in_zigzag;
		if (done) begin
			push_tag.status = ST_OK;
		end else if (overlong) begin
			push_tag.status = ST_OVERLONG;
		end else begin
			push_tag.status = ST_TRUNCATED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			group_q <= '0;
		end else if (accept) begin
			if (push) begin
				accum_q <= '0;
				group_q <= '0;
			end else begin
				accum_q <= acc_next;
				group_q <= cnt;
			end
		end
	end

endmodule

// ----- hw/rtl/leb_back.sv -----
// ---------------------------------------------------------------------------
// LEB128 result back end
// Pops finished numbers, applies zig-zag decoding when the tag selects it
// and holds the result in the output register until the consumer takes it.
// ---------------------------------------------------------------------------
module leb_back
	import leb_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  logic [VALUE_BITS-1:0] q_value,
	input  leb_tag_t              q_tag,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           out_value,
	output leb_status_t           out_status,
	output logic [COUNT_W-1:0]    out_count
);

	logic                  valid_q;
	logic [VALUE_BITS-1:0] value_q;
	leb_tag_t              tag_q;
	logic [VALUE_BITS-1:0] decoded;

	// zig-zag within VALUE_BITS: (v >> 1) ^ -(v & 1)
	assign decoded = q_tag.zigzag
		? ({1'b0, q_value[VALUE_BITS-1:1]} ^ {VALUE_BITS{q_value[0]}})
		: q_value;

	assign q_pop = q_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_q <= decoded;
			tag_q   <= q_tag;
		end
	end

	assign out_valid  = valid_q;
	assign out_value  = 64'(value_q);
	assign out_status = tag_q.status;
	assign out_count  = tag_q.byte_count;

endmodule

// ----- test/leb128_varint_decoder_checker.sv -----
// ---------------------------------------------------------------------------
// LEB128 varint decoder checker
// Watches both stream channels. Predicts the result of every number that
// an accepted byte finishes and compares each result transaction, field by
// field, against the oldest pending prediction.
// ---------------------------------------------------------------------------
module leb128_varint_decoder_checker
	import leb_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,   // [0] zigzag_mode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,   // [63:0] value, [67:64] byte_count, [71:68] zero
	input  logic [1:0]  m_axis_tuser,   // [1:0] status
	output int          failures,
	output int          pending
);

	localparam int          MAX_GROUPS   = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
	localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_BITS);
	localparam logic [7:0]  MORE_BIT     = 8'h80;
	localparam logic [7:0]  PAYLOAD_MASK = 8'h7f;

	typedef struct {
		logic [63:0]        value;
		leb_status_t        status;
		logic [COUNT_W-1:0] byte_count;
	} decoded_number_t;

	decoded_number_t    numbers_due[$];
	logic [63:0]        partial;
	logic [COUNT_W-1:0] groups_seen;

	function automatic logic [63:0] unzigzag(logic [63:0] v);
		return ((v >> 1) ^ (64'd0 - {63'd0, v[0]})) & VALUE_MASK;
	endfunction

	initial begin
		failures = 0;
		pending  = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		int                 shift;
		logic [COUNT_W-1:0] count;
		logic [63:0]        word;
		decoded_number_t    due;
		if (!arst_n) begin
			partial     = '0;
			groups_seen = '0;
			numbers_due.delete();
			pending     = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (numbers_due.size() == 0) begin
					failures++;
					$display("%0t: result with nothing pending: expected none, actual value %h count %0d status %0d",
						$time, m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tuser);
				end else begin
					due = numbers_due.pop_front();
					if (m_axis_tdata[63:0] !== due.value) begin
						failures++;
						$display("%0t: value mismatch: expected %h actual %h",
							$time, due.value, m_axis_tdata[63:0]);
					end
					if (m_axis_tdata[67:64] !== due.byte_count) begin
						failures++;
						$display("%0t: byte_count mismatch: expected %0d actual %0d",
							$time, due.byte_count, m_axis_tdata[67:64]);
					end
					if (m_axis_tuser !== due.status) begin
						failures++;
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, due.status, m_axis_tuser);
					end
					if (m_axis_tdata[71:68] !== 4'd0) begin
						failures++;
						$display("%0t: tdata padding mismatch: expected 0 actual %h",
							$time, m_axis_tdata[71:68]);
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				shift = groups_seen * GROUP_BITS;
				count = groups_seen + 1'b1;
				// drop payload bits that land past bit 63
				if (shift < 64)
					partial = partial | ({56'd0, s_axis_tdata & PAYLOAD_MASK} << shift);
				if ((s_axis_tdata & MORE_BIT) == 8'd0) begin
					word = partial & VALUE_MASK;
					due.value      = s_axis_tuser ? unzigzag(word) : word;
					due.status     = ST_OK;
					due.byte_count = count;
					numbers_due.insert(numbers_due.size(), due);
					partial     = '0;
					groups_seen = '0;
				end else if (count >= MAX_GROUPS) begin
					// overlong wins over truncation
					due.value      = '0;
					due.status     = ST_OVERLONG;
					due.byte_count = count;
					numbers_due.insert(numbers_due.size(), due);
					partial     = '0;
					groups_seen = '0;
				end else if (s_axis_tlast) begin
					due.value      = '0;
					due.status     = ST_TRUNCATED;
					due.byte_count = count;
					numbers_due.insert(numbers_due.size(), due);
					partial     = '0;
					groups_seen = '0;
				end else begin
					groups_seen = count;
				end
			end
			pending = numbers_due.size();
		end
	end

endmodule

// ----- test/leb128_varint_decoder_test.sv -----
// ---------------------------------------------------------------------------
// LEB128 varint decoder testbench
// Feeds directed edge-case numbers and then a long random byte stream,
// mostly well-formed numbers with some truncated, overlong and noise bytes,
// with random idling on both channels and one long output stall.
// ---------------------------------------------------------------------------
module leb128_varint_decoder_test;
	import leb_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 12;
	localparam int RANDOM_ITEMS    = 1650;
	localparam int MAX_GROUPS      = (64 + GROUP_BITS - 1) / GROUP_BITS;
	localparam int HOLD_OFF_AFTER  = 400;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 2000;
	localparam int TAIL_CYCLES     = 8;
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       zigzag;
	} stream_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] byte_in
	logic        s_axis_tlast;
	logic        s_axis_tuser;   // [0] zigzag_mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // [63:0] value, [67:64] byte_count, [71:68] zero
	logic [1:0]  m_axis_tuser;   // [1:0] status

	int           failures;
	int           pending;
	int           bytes_sent = 0;
	logic         sending_done = 1'b0;
	stream_byte_t byte_plan[$];

	always #HALF_PERIOD clk = ~clk;

	leb128_varint_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	leb128_varint_decoder_checker number_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.failures      (failures),
		.pending       (pending)
	);

	// mostly short gaps, a few long ones, and now and then a quiet stretch
	function automatic int idle_cycles(inout int quiet_left);
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			quiet_left = $urandom_range(20, 80);
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [6:0] random_payload();
		case ($urandom_range(0, 7))
			0: return 7'h7f;
			1: return 7'h00;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic push_byte(logic [7:0] data, logic last, logic zigzag);
		stream_byte_t b;
		b.data   = data;
		b.last   = last;
		b.zigzag = zigzag;
		byte_plan.insert(byte_plan.size(), b);
	endtask

	task automatic push_number(int len);
		repeat (len - 1)
			push_byte({1'b1, random_payload()}, 1'b0, 1'($urandom_range(0, 1)));
		push_byte({1'b0, random_payload()}, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// continuation bytes only: truncated or overlong depending on length
	task automatic push_unfinished(int len, logic last_at_end);
		for (int k = 0; k < len; k++)
			push_byte({1'b1, random_payload()}, (k == len - 1) ? last_at_end : 1'b0,
				1'($urandom_range(0, 1)));
	endtask

	initial begin : sender
		int quiet_tx;
		int gap;
		int directed;
		quiet_tx = 0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'd0;
		s_axis_tlast  <= 1'b0;
		s_axis_tuser  <= 1'b0;

		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h7f, 1'b1, 1'b1);
		push_byte(8'h80, 1'b0, 1'b0);
		push_byte(8'h01, 1'b0, 1'b0);
		push_byte(8'h80, 1'b1, 1'b0);
		// longest number, top payload bits dropped, zig-zag at full width
		repeat (MAX_GROUPS - 1) push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'h7f, 1'b0, 1'b1);
		// overlong with end of data on the same byte
		repeat (MAX_GROUPS - 1) push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'hff, 1'b1, 1'b0);
		directed = byte_plan.size();

		while (byte_plan.size() < directed + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				6: push_unfinished($urandom_range(1, MAX_GROUPS - 1), 1'b1);
				7: push_unfinished(MAX_GROUPS, 1'($urandom_range(0, 1)));
				8, 9: begin
					repeat ($urandom_range(1, 4))
						push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
							1'($urandom_range(0, 1)));
				end
				default: begin
					if ($urandom_range(0, 3) == 0)
						push_number($urandom_range(4, MAX_GROUPS));
					else
						push_number($urandom_range(1, 3));
				end
			endcase
		end

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (byte_plan[i]) begin
			gap = idle_cycles(quiet_tx);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= byte_plan[i].data;
			s_axis_tlast  <= byte_plan[i].last;
			s_axis_tuser  <= byte_plan[i].zigzag;
			do
				@(posedge clk);
			while (!s_axis_tready);
			bytes_sent++;
		end
		s_axis_tvalid <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin : receiver
		int quiet_rx;
		int stall;
		bit held_off;
		quiet_rx = 0;
		held_off = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// stall the output long enough to fill the queue and block the input
			if (!held_off && bytes_sent >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				for (int c = 0; c < HOLD_OFF_CYCLES; c++)
					@(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			stall = idle_cycles(quiet_rx);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : supervisor
		int waited;
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		wait (sending_done);
		@(posedge clk);
		waited = 0;
		while (pending != 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/leb_pkg.sv
hw/rtl/leb_fifo.sv
hw/rtl/leb_front.sv
hw/rtl/leb_back.sv
hw/rtl/leb128_varint_decoder.sv
test/leb128_varint_decoder_checker.sv
test/leb128_varint_decoder_test.sv
